// File: design/rms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types for the range median select block.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_PUT,
    ST_DONE,
    ST_MA,
    ST_MB,
    ST_OUT
  } back_state_t;

endpackage

// File: design/range_median_select_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_median_select_top
// Streaming median of a set of signed 32-bit words.
// ----------------------------------------------------------------------------
// Input words carry one signed sample in in_tdata; in_tuser marks the last
// word of a set. Samples are insertion-sorted into a MAX_ITEMS-deep RAM.
// On the last word one result word leaves: out_tdata is the median (even
// sets average the middle pair, truncated toward zero), out_tuser flags that
// samples beyond MAX_ITEMS were dropped.
// The time a sample takes grows with k, the number of stored entries larger
// than it, as the RAM's single read port and single write port walk the
// sorted store one entry a cycle; an empty or a full store needs no walk. A
// last word adds the median readout: ST_MA, ST_MB for an even set, ST_OUT.
// A two-word queue in front lets input continue while the sorter works.
// Reset empties the queue, the count and the output register; RAM content
// is left as is. When the receiver stalls, the result waits in the output
// register and the sorter holds before its next result.
// ----------------------------------------------------------------------------
module range_median_select_top import rms_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_value
  input  logic        in_tuser,   // [0] last_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] median_value
  output logic        out_tuser   // [0] overflow
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  rms_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  rms_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

// File: design/rms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/rms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_front
// Input acceptor: two-entry word queue toward the sorter.
// ----------------------------------------------------------------------------
module rms_front import rms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t      buf_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = buf_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= '{value: in_tdata, last: in_tuser};
    end
  end

endmodule

// File: design/rms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_back
// Insertion sorter over the store RAM and median readout.
// ----------------------------------------------------------------------------
module rms_back import rms_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tuser
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

  back_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] lo_r, lo_nxt;
  logic signed [31:0] med_r, med_nxt;
  logic last_r, last_nxt;
  logic ovf_r, ovf_nxt;
  logic ovld_r, ovld_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic ouser_r, ouser_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  logic signed [32:0] sum;
  logic signed [32:0] half;

  rms_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign sum  = {lo_r[31], lo_r} + {rdata[31], rdata};
  assign half = (sum + {32'd0, sum[32]}) >>> 1;

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) begin
        if (cnt_r >= MAX_C || cnt_r == '0) state_nxt = ST_DONE;
        else state_nxt = ST_CMP;
      end
      ST_CMP: if ($signed(rdata) > val_r) begin
        if (pos_r == CW'(1)) state_nxt = ST_PUT;
      end else begin
        state_nxt = ST_DONE;
      end
      ST_PUT:  state_nxt = ST_DONE;
      ST_DONE: state_nxt = last_r ? ST_MA : ST_IDLE;
      ST_MA:   state_nxt = cnt_r[0] ? ST_OUT : ST_MB;
      ST_MB:   state_nxt = ST_OUT;
      ST_OUT:  if (!ovld_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = pos_r[AW-1:0];
    wdata     = val_r;
    raddr     = '0;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    lo_nxt    = lo_r;
    med_nxt   = med_r;
    last_nxt  = last_r;
    ovf_nxt   = ovf_r;
    ovld_nxt  = ovld_r && !out_tready;
    odata_nxt = odata_r;
    ouser_nxt = ouser_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) begin
        q_pop    = 1'b1;
        val_nxt  = q_item.value;
        last_nxt = q_item.last;
        if (cnt_r >= MAX_C) begin
          ovf_nxt = 1'b1;
        end else if (cnt_r == '0) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = q_item.value;
          cnt_nxt = CW'(1);
        end else begin
          pos_nxt = cnt_r;
          raddr   = AW'(cnt_r - CW'(1));
        end
      end
      ST_CMP: begin
        we = 1'b1;
        if ($signed(rdata) > val_r) begin
          wdata   = rdata;
          pos_nxt = pos_r - CW'(1);
          raddr   = AW'(pos_r - CW'(2));
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_PUT: begin
        we      = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
      end
      ST_DONE: begin
        if (cnt_r[0]) raddr = AW'(cnt_r >> 1);
        else          raddr = AW'((cnt_r - CW'(1)) >> 1);
      end
      ST_MA: begin
        lo_nxt  = rdata;
        med_nxt = rdata;
        raddr   = AW'(cnt_r >> 1);
      end
      ST_MB: med_nxt = half[31:0];
      ST_OUT: if (!ovld_r || out_tready) begin
        ovld_nxt  = 1'b1;
        odata_nxt = med_r;
        ouser_nxt = ovf_r;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    lo_r    <= lo_nxt;
    med_r   <= med_nxt;
    last_r  <= last_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

endmodule

// File: design/rms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks for the range median select block.
// ----------------------------------------------------------------------------
module rms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed under stall");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind range_median_select_top rms_checker u_rms_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for range_median_select_top.
// ----------------------------------------------------------------------------
// Streams sets of signed samples with random burst/gap timing on the input and
// random stalls on the output. A behavioral sorter computes each set's median
// and overflow flag; result words are compared in order against it. A short
// table of directed words covers extremes, even/odd sets and duplicates; a set
// that overruns the store and one that fills it exactly, then small random sets follow.
// ----------------------------------------------------------------------------
module testbench;
  import rms_pkg::*;

  localparam int unsigned DEPTH = 256;

  typedef struct packed {
    logic signed [31:0] median;
    logic               ovf;
  } median_t;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               chk;
    median_t            want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  range_median_select_top #(.MAX_ITEMS(DEPTH)) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [31:0] sorted_q[$];
  logic               set_ovf = 1'b0;
  median_t            median_q[$];
  median_t            typed_q[$];
  logic               typed_chk_q[$];
  int                 errors = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sorted insert, median of stored samples at set end
  function automatic void median_accept(input logic signed [31:0] v, input logic last);
    int                 pos;
    longint             a, b;
    median_t            r;
    if (sorted_q.size() < DEPTH) begin
      pos = sorted_q.size();
      while (pos > 0 && sorted_q[pos-1] > v) pos--;
      sorted_q.insert(pos, v);
    end else begin
      set_ovf = 1'b1;
    end
    if (last) begin
      if (sorted_q.size() % 2 == 0) begin
        a = sorted_q[sorted_q.size()/2 - 1];
        b = sorted_q[sorted_q.size()/2];
        r.median = 32'((a + b) / 2);
      end else begin
        r.median = sorted_q[sorted_q.size()/2];
      end
      r.ovf = set_ovf;
      median_q.push_back(r);
      sorted_q.delete();
      set_ovf = 1'b0;
    end
  endfunction

  int stall_mode;
  always @(posedge clk) begin
    stall_mode <= $urandom_range(0, 2000) == 0 ? $urandom_range(0, 2) : stall_mode;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 3) != 0;
      default: out_tready <= $urandom_range(0, 3) == 0;
    endcase
  end

  always @(posedge clk) begin
    median_t exp_r;
    if (out_tvalid && out_tready) begin
      if (median_q.size() == 0) begin
        report("unexpected word", out_tdata, 32'h0);
      end else begin
        exp_r = median_q.pop_front();
        if (typed_chk_q.size() > 0 && typed_chk_q[0]) begin
          if (typed_q[0] != exp_r) report("table vs predictor", typed_q[0].median, exp_r.median);
        end
        if (typed_chk_q.size() > 0) begin
          void'(typed_chk_q.pop_front());
          void'(typed_q.pop_front());
        end
        if (out_tdata !== exp_r.median) report("median_value", out_tdata, exp_r.median);
        if (out_tuser !== exp_r.ovf) report("overflow", out_tuser, exp_r.ovf);
      end
    end
  end

  int burst = 0;

  task automatic send_word(input logic signed [31:0] v, input logic last);
    int gap;
    if (burst == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    median_accept(v, last);
    burst--;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  row_t table_rows[$];

  function automatic row_t mk(input logic signed [31:0] v, input logic last,
                              input logic chk = 1'b0, input logic signed [31:0] m = 0,
                              input logic ovf = 1'b0);
    row_t r;
    r.value = v; r.last = last; r.chk = chk; r.want = '{m, ovf};
    return r;
  endfunction

  initial begin
    int n;
    table_rows.push_back(mk(32'sh7fff_ffff, 1, 1, 32'sh7fff_ffff));
    table_rows.push_back(mk(32'sh8000_0000, 1, 1, 32'sh8000_0000));
    table_rows.push_back(mk(32'sh7fff_ffff, 0));
    table_rows.push_back(mk(32'sh7fff_ffff, 1, 1, 32'sh7fff_ffff));
    table_rows.push_back(mk(32'sh8000_0000, 0));
    table_rows.push_back(mk(32'sh8000_0000, 1, 1, 32'sh8000_0000));
    table_rows.push_back(mk(32'sh8000_0000, 0));
    table_rows.push_back(mk(32'sh7fff_ffff, 1, 1, 0));
    table_rows.push_back(mk(-3, 0));
    table_rows.push_back(mk(0, 1, 1, -1));
    table_rows.push_back(mk(3, 0));
    table_rows.push_back(mk(0, 1, 1, 1));
    table_rows.push_back(mk(9, 0));
    table_rows.push_back(mk(5, 0));
    table_rows.push_back(mk(5, 0));
    table_rows.push_back(mk(1, 1, 1, 5));
    table_rows.push_back(mk(32'shffff_ffff, 0));
    table_rows.push_back(mk(32'sh5555_aaaa, 0));
    table_rows.push_back(mk(32'shaaaa_5555, 1));
    table_rows.push_back(mk(4, 0));
    table_rows.push_back(mk(2, 0));
    table_rows.push_back(mk(8, 0));
    table_rows.push_back(mk(6, 1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      if (table_rows[i].last) begin
        typed_q.push_back(table_rows[i].want);
        typed_chk_q.push_back(table_rows[i].chk);
      end
      send_word(table_rows[i].value, table_rows[i].last);
    end

    // overrun: full store, then an extra middle word and an extreme last word
    for (int k = 0; k < DEPTH; k++) send_word(rand_sample(), 1'b0);
    send_word(32'sh7fff_ffff, 1'b0);
    send_word(32'sh8000_0000, 1'b1);
    // exactly full, no overflow
    for (int k = 0; k < DEPTH - 1; k++) send_word(32'(k), 1'b0);
    send_word(32'sh8000_0000, 1'b1);

    for (int s = 0; s < 30; s++) begin
      n = $urandom_range(1, 9);
      for (int k = 1; k <= n; k++) send_word(rand_sample(), k == n);
    end
    in_tvalid <= 1'b0;

    while (median_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
